// ===== rtl/bfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit free rectangle selector: shared types and constants
// Field widths, request and result payloads, stage bundles, register indexes.
// ----------------------------------------------------------------------------
package bfrs_pkg;

	localparam int COORD_BITS = 24;
	localparam int NEED_BITS  = 23;
	// common width for size against board comparisons
	localparam int DIM_BITS   = (COORD_BITS > NEED_BITS) ? COORD_BITS : NEED_BITS;
	localparam int AREA_BITS  = 2 * COORD_BITS;
	// leftover strip products: (size - board) * board or (size - board) * size
	localparam int LEFT_BITS  = (COORD_BITS + NEED_BITS > AREA_BITS) ?
		(COORD_BITS + NEED_BITS) : AREA_BITS;

	typedef enum logic [0:0] {
		CFG_NEED_WIDTH  = 1'b0,
		CFG_NEED_HEIGHT = 1'b1
	} cfg_index_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0]        len_t;
	typedef logic [NEED_BITS-1:0]         need_t;
	typedef logic [AREA_BITS-1:0]         area_t;
	typedef logic [LEFT_BITS-1:0]         left_t;

	typedef struct packed {
		coord_t rect_xmin;
		coord_t rect_ymin;
		coord_t rect_xmax;
		coord_t rect_ymax;
		logic   is_space;
		logic   last;
	} rect_t;

	typedef struct packed {
		logic   found;
		coord_t place_x;
		coord_t place_y;
		logic   rotated;
	} result_t;

	// size check stage
	typedef struct packed {
		logic   cand;
		logic   up_fit;
		logic   turn_fit;
		logic   last;
		len_t   w;
		len_t   h;
		coord_t x;
		coord_t y;
	} fit_t;

	// product stage
	typedef struct packed {
		logic   cand;
		logic   up_fit;
		logic   turn_fit;
		logic   last;
		area_t  area;
		left_t  up_a;
		left_t  up_b;
		left_t  turn_a;
		left_t  turn_b;
		coord_t x;
		coord_t y;
	} cost_t;

	// orientation stage
	typedef struct packed {
		logic   cand;
		logic   last;
		logic   rot;
		area_t  area;
		coord_t x;
		coord_t y;
	} pick_t;

endpackage

// ===== rtl/best_fit_free_rect_select.sv =====
// ----------------------------------------------------------------------------
// best_fit_free_rect_select: smallest free rectangle that holds a board
// Streams candidate rectangles, returns the best-area fit and its rotation.
// ----------------------------------------------------------------------------
// Usage
//   Write need_width and need_height through cfg_we/cfg_index/cfg_data while
//   the block is idle; both reset to 1.
//   Requests arrive on rect_valid/rect/rect_stall, one rectangle per cycle while rect_stall is low.
//   Every request is checked; only the one flagged last produces a result,
//   on result_valid/result/result_stall.
//   The last request passes the request register, size check, multipliers and
//   orientation compare, then its result is held in the result register.
//   Throughput: one request per cycle while rect_stall is low, set by the
//   single compare-and-keep against the stored best area.
//   Stall: a waiting result does not block the pipe; rect_stall rises only
//   when a further last request reaches the keep stage while the result
//   register is still held by result_stall.
//   Reset: clears the pipe valid flags, the best-fit state and the result
//   valid; there is no clearing pass.
// ----------------------------------------------------------------------------
module best_fit_free_rect_select import bfrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  need_t      cfg_data,
	input  logic       rect_valid,
	output logic       rect_stall,
	input  rect_t      rect,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	need_t need_width_q, need_height_q;
	logic  run, take, hold;
	logic  fit_vld, pick_vld;
	fit_t  fit;
	pick_t pick;

	// board size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_width_q  <= NEED_BITS'(1);
			need_height_q <= NEED_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NEED_WIDTH:  need_width_q  <= cfg_data;
				CFG_NEED_HEIGHT: need_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the whole pipe only while a last request waits for the result slot
	assign run        = !hold;
	assign take       = rect_valid && run;
	assign rect_stall = !run;

	bfrs_fit u_fit (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (run),
		.take        (take),
		.rect        (rect),
		.need_width  (need_width_q),
		.need_height (need_height_q),
		.fit_vld     (fit_vld),
		.fit         (fit)
	);

	bfrs_cost u_cost (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (run),
		.fit_vld     (fit_vld),
		.fit         (fit),
		.need_width  (need_width_q),
		.need_height (need_height_q),
		.pick_vld    (pick_vld),
		.pick        (pick)
	);

	bfrs_keep u_keep (
		.clk          (clk),
		.arst_n       (arst_n),
		.pick_vld     (pick_vld),
		.pick         (pick),
		.result_stall (result_stall),
		.hold         (hold),
		.result_valid (result_valid),
		.result       (result)
	);

	// input back-pressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rect_stall |-> (result_valid && result_stall))
		else $error("request stalled without a blocked result");

	// a fresh result must come from a last request leaving the keep stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !($past(result_valid) && $past(result_stall)))
		|-> $past(pick_vld && pick.last && !hold))
		else $error("result without a last request");

	// an empty search reports all-zero placement
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found)
		|-> (result.place_x == '0 && result.place_y == '0 && !result.rotated))
		else $error("empty result carries a placement");

endmodule

// ===== rtl/bfrs_fit.sv =====
// ----------------------------------------------------------------------------
// bfrs_fit: request register and size check
// Registers the request, forms candidate width and height, checks both fits.
// ----------------------------------------------------------------------------
module bfrs_fit import bfrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  run,
	input  logic  take,
	input  rect_t rect,
	input  need_t need_width,
	input  need_t need_height,
	output logic  fit_vld,
	output fit_t  fit
);

	rect_t rect_s1;
	logic  vld_s1;
	fit_t  fit_s2;
	logic  vld_s2;

	logic signed [COORD_BITS:0] sw, sh;
	logic  nonneg;
	len_t  w, h;
	logic  up_fit, turn_fit;
	fit_t  fit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (run) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rect_s1 <= rect;
		end
		if (run) begin
			fit_s2 <= fit_d;
		end
	end

	always_comb begin
		sw = {rect_s1.rect_xmax[COORD_BITS-1], rect_s1.rect_xmax} -
			{rect_s1.rect_xmin[COORD_BITS-1], rect_s1.rect_xmin};
		sh = {rect_s1.rect_ymax[COORD_BITS-1], rect_s1.rect_ymax} -
			{rect_s1.rect_ymin[COORD_BITS-1], rect_s1.rect_ymin};
		// an inverted rectangle never fits
		nonneg   = !sw[COORD_BITS] && !sh[COORD_BITS];
		w        = sw[COORD_BITS-1:0];
		h        = sh[COORD_BITS-1:0];
		up_fit   = nonneg && (DIM_BITS'(w) >= DIM_BITS'(need_width)) &&
			(DIM_BITS'(h) >= DIM_BITS'(need_height));
		turn_fit = nonneg && (DIM_BITS'(h) >= DIM_BITS'(need_width)) &&
			(DIM_BITS'(w) >= DIM_BITS'(need_height));

		fit_d.cand     = rect_s1.is_space && (up_fit || turn_fit);
		fit_d.up_fit   = up_fit;
		fit_d.turn_fit = turn_fit;
		fit_d.last     = rect_s1.last;
		fit_d.w        = w;
		fit_d.h        = h;
		fit_d.x        = rect_s1.rect_xmin;
		fit_d.y        = rect_s1.rect_ymin;
	end

	assign fit_vld = vld_s2;
	assign fit     = fit_s2;

endmodule

// ===== rtl/bfrs_cost.sv =====
// ----------------------------------------------------------------------------
// bfrs_cost: area, leftover strips and orientation
// One stage of multipliers, then a stage that compares the strips.
// ----------------------------------------------------------------------------
module bfrs_cost import bfrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  run,
	input  logic  fit_vld,
	input  fit_t  fit,
	input  need_t need_width,
	input  need_t need_height,
	output logic  pick_vld,
	output pick_t pick
);

	cost_t cost_s3;
	logic  vld_s3;
	pick_t pick_s4;
	logic  vld_s4;

	len_t  dw_w, dh_h, dw_h, dh_w;
	logic [COORD_BITS+NEED_BITS-1:0] pa, pc;
	area_t pb, pd, area;
	cost_t cost_d;
	left_t up_max, turn_max;
	pick_t pick_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (run) begin
			vld_s3 <= fit_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			cost_s3 <= cost_d;
			pick_s4 <= pick_d;
		end
	end

	// differences are only used where they are nonnegative and below 2^COORD_BITS
	always_comb begin
		dw_w = COORD_BITS'(DIM_BITS'(fit.w) - DIM_BITS'(need_width));
		dh_h = COORD_BITS'(DIM_BITS'(fit.h) - DIM_BITS'(need_height));
		dw_h = COORD_BITS'(DIM_BITS'(fit.w) - DIM_BITS'(need_height));
		dh_w = COORD_BITS'(DIM_BITS'(fit.h) - DIM_BITS'(need_width));
		pa   = dw_w * need_height;
		pb   = dh_h * fit.w;
		pc   = dw_h * need_width;
		pd   = dh_w * fit.w;
		area = fit.w * fit.h;

		cost_d.cand     = fit.cand;
		cost_d.up_fit   = fit.up_fit;
		cost_d.turn_fit = fit.turn_fit;
		cost_d.last     = fit.last;
		cost_d.area     = area;
		cost_d.up_a     = LEFT_BITS'(pa);
		cost_d.up_b     = LEFT_BITS'(pb);
		cost_d.turn_a   = LEFT_BITS'(pc);
		cost_d.turn_b   = LEFT_BITS'(pd);
		cost_d.x        = fit.x;
		cost_d.y        = fit.y;
	end

	// forced orientation if only one fits, else turn when upright leaves less
	always_comb begin
		up_max   = (cost_s3.up_a > cost_s3.up_b) ? cost_s3.up_a : cost_s3.up_b;
		turn_max = (cost_s3.turn_a > cost_s3.turn_b) ? cost_s3.turn_a : cost_s3.turn_b;

		pick_d.cand = cost_s3.cand;
		pick_d.last = cost_s3.last;
		pick_d.rot  = !cost_s3.up_fit || (cost_s3.turn_fit && (up_max < turn_max));
		pick_d.area = cost_s3.area;
		pick_d.x    = cost_s3.x;
		pick_d.y    = cost_s3.y;
	end

	assign pick_vld = vld_s4;
	assign pick     = pick_s4;

endmodule

// ===== rtl/bfrs_keep.sv =====
// ----------------------------------------------------------------------------
// bfrs_keep: best candidate state and result register
// Keeps the smallest fitting area, emits and clears on the last request.
// ----------------------------------------------------------------------------
module bfrs_keep import bfrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pick_vld,
	input  pick_t   pick,
	input  logic    result_stall,
	output logic    hold,
	output logic    result_valid,
	output result_t result
);

	logic    have_q;
	coord_t  bx_q, by_q;
	area_t   area_q;
	logic    rot_q;
	logic    res_valid_q;
	result_t res_q;

	logic    fire, better;
	logic    n_have, n_rot;
	coord_t  n_x, n_y;
	area_t   n_area;

	always_comb begin
		hold   = pick_vld && pick.last && res_valid_q && result_stall;
		fire   = pick_vld && !hold;
		better = fire && pick.cand && (!have_q || (pick.area < area_q));
		n_have = have_q || better;
		n_x    = better ? pick.x    : bx_q;
		n_y    = better ? pick.y    : by_q;
		n_area = better ? pick.area : area_q;
		n_rot  = better ? pick.rot  : rot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire && pick.last) begin
				have_q      <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				have_q <= n_have;
				if (!result_stall) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		bx_q   <= n_x;
		by_q   <= n_y;
		area_q <= n_area;
		rot_q  <= n_rot;
		if (fire && pick.last) begin
			res_q.found   <= n_have;
			res_q.place_x <= n_have ? n_x : '0;
			res_q.place_y <= n_have ? n_y : '0;
			res_q.rotated <= n_have && n_rot;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
